// File: hdl/ksps_pkg.sv
package ksps_pkg;

  // Saturated configuration as seen by the datapath
  typedef struct packed {
    logic [5:0]  n;
    logic [11:0] base;
    logic [15:0] zq;
    logic [12:0] cx;
    logic [12:0] cy;
    logic [8:0]  w;
    logic [8:0]  h;
    logic        full;
  } ksps_cfg_t;

  // Classified command from the front end
  typedef struct packed {
    logic               render;
    logic [7:0]         px;
    logic [7:0]         py;
    logic [7:0]         y;
    logic [7:0]         u;
    logic [7:0]         v;
    logic signed [10:0] dx2;
    logic signed [10:0] dy2;
  } ksps_cmd_t;

  localparam int DIV_W = 14;
  localparam int DIV_D = 6;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } ksps_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_D-1:0] rem;
  } ksps_div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ANG_GO, B_ANG_WAIT, B_MUL, B_GET, B_ADDR, B_READ,
    B_Y_GO, B_Y_WAIT, B_U_GO, B_U_WAIT, B_V_GO, B_V_WAIT, B_OUT
  } ksps_state_t;

  typedef enum logic [3:0] {
    CFG_SEGMENTS = 4'd0, CFG_ANGLE = 4'd1, CFG_ZOOM = 4'd2, CFG_CX = 4'd3,
    CFG_CY = 4'd4, CFG_WIDTH = 4'd5, CFG_HEIGHT = 4'd6, CFG_RANGE = 4'd7
  } ksps_cfg_idx_t;

  // Sequencer steps of one segment
  localparam logic [4:0] ST_COS  = 5'd6;
  localparam logic [4:0] ST_ZS   = 5'd12;
  localparam logic [4:0] ST_ZC   = 5'd13;
  localparam logic [4:0] ST_X0   = 5'd14;
  localparam logic [4:0] ST_X1   = 5'd15;
  localparam logic [4:0] ST_Y0   = 5'd16;
  localparam logic [4:0] ST_LAST = 5'd17;

  // Steps within one quarter sine evaluation
  localparam logic [2:0] LS_U2 = 3'd0;
  localparam logic [2:0] LS_H9 = 3'd1;
  localparam logic [2:0] LS_H5 = 3'd2;
  localparam logic [2:0] LS_H3 = 3'd3;
  localparam logic [2:0] LS_H1 = 3'd4;
  localparam logic [2:0] LS_R  = 3'd5;

  localparam logic signed [32:0] PC1 = 33'sd1686629713;
  localparam logic signed [32:0] PC3 = -33'sd693598668;
  localparam logic signed [32:0] PC5 = 33'sd85569306;
  localparam logic signed [32:0] PC7 = -33'sd5026995;
  localparam logic [30:0]        PC9 = 31'd172272;

  localparam logic [15:0] ZOOM_MIN = 16'd1638;
  localparam logic [15:0] ZOOM_MAX = 16'd49152;
  localparam logic [7:0]  CHROMA_OFFSET = 8'd128;
  localparam logic [7:0]  LIM_LO   = 8'd16;
  localparam logic [7:0]  LIM_Y_HI = 8'd235;
  localparam logic [7:0]  LIM_C_HI = 8'd240;

endpackage

// File: hdl/ksps_ram.sv
module ksps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

// File: hdl/ksps_div.sv
module ksps_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ksps_pkg::ksps_div_req_t req,
  output ksps_pkg::ksps_div_rsp_t rsp
);
  import ksps_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quot_r, quot_nxt;
  logic [DIV_D-1:0] rem_r, rem_nxt;
  logic [DIV_D-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DIV_D:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, quot_r[DIV_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = fits ? DIV_D'(trial - {1'b0, dvs_r}) : trial[DIV_D-1:0];
    quot_nxt = {quot_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        quot_r <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quot_r <= quot_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hdl/ksps_front.sv
module ksps_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ksps_pkg::ksps_cfg_t cfg,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_opcode,
  input  logic [7:0]          in_pixel_x,
  input  logic [7:0]          in_pixel_y,
  input  logic [7:0]          in_luma_in,
  input  logic [7:0]          in_cb_in,
  input  logic [7:0]          in_cr_in,
  output logic                head_valid,
  output ksps_pkg::ksps_cmd_t head,
  input  logic                head_pop
);
  import ksps_pkg::*;

  ksps_cmd_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  ksps_cmd_t  cmd;
  logic       in_range, enq, deq;

  always_comb begin
    in_range   = (int'(in_pixel_x) < MAX_WIDTH) && (int'(in_pixel_y) < MAX_HEIGHT);
    cmd.render = in_opcode;
    cmd.px     = in_pixel_x;
    cmd.py     = in_pixel_y;
    cmd.y      = in_luma_in;
    cmd.u      = in_cb_in;
    cmd.v      = in_cr_in;
    cmd.dx2    = $signed({2'b00, in_pixel_x, 1'b0}) - $signed({2'b00, cfg.w - 9'd1});
    cmd.dy2    = $signed({2'b00, in_pixel_y, 1'b0}) - $signed({2'b00, cfg.h - 9'd1});
  end

  assign in_full    = cnt_r == 2'd2;
  // drop loads that fall outside the store
  assign enq        = in_push && !in_full && (in_opcode || in_range);
  assign deq        = head_pop && head_valid;
  assign head_valid = cnt_r != 2'd0;
  assign head       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (enq) begin
        q_r[wp_r] <= cmd;
        wp_r      <= !wp_r;
      end
      if (deq) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

// File: hdl/ksps_back.sv
module ksps_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ksps_pkg::ksps_cfg_t                      cfg,
  input  logic                                     head_valid,
  input  ksps_pkg::ksps_cmd_t                      head,
  output logic                                     head_pop,
  output ksps_pkg::ksps_div_req_t                  div_req,
  input  ksps_pkg::ksps_div_rsp_t                  div_rsp,
  output logic                                     ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  ram_addr,
  output logic [23:0]                              ram_wdata,
  input  logic [23:0]                              ram_rdata,
  output logic                                     out_empty,
  input  logic                                     out_pop,
  output logic [7:0]                               out_luma_out,
  output logic [7:0]                               out_cb_out,
  output logic [7:0]                               out_cr_out
);
  import ksps_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  ksps_state_t state_r, state_nxt;

  ksps_cmd_t          cmd_r;
  logic [4:0]         mstep_r;
  logic [5:0]         seg_r;
  logic [12:0]        astep_r, offq_r;
  logic [5:0]         arem_r, offr_r;
  logic [61:0]        prod_r;
  logic               pneg_r;
  logic [30:0]        u2_r;
  logic signed [32:0] p_r;
  logic signed [15:0] sin_r, cos_r;
  logic signed [31:0] sn_r, cs_r;
  logic signed [42:0] accx_r, accy_r;
  logic [13:0]        acc_y_r;
  logic signed [14:0] acc_u_r, acc_v_r;
  logic [7:0]         res_y_r, res_u_r, res_v_r;
  logic               out_valid_r;
  logic [7:0]         out_y_r, out_u_r, out_v_r;

  // combinational
  logic               pass;
  logic [2:0]         lstep;
  logic [11:0]        ang, ang_p;
  logic [10:0]        tq;
  logic [30:0]        uq;
  logic [30:0]        ma, mb;
  logic               mn;
  logic [32:0]        pabs;
  logic [31:0]        snabs, csabs;
  logic [10:0]        dxabs, dyabs;
  logic signed [32:0] sq30;
  logic signed [62:0] sp;
  logic [32:0]        rpos, rsum;
  logic [16:0]        rs;
  logic [14:0]        mq;
  logic signed [15:0] trig;
  logic signed [13:0] sx_f, sy_f;
  logic [8:0]         sx, sy;
  logic [38:0]        bx, by;
  logic [6:0]         nrem;
  logic               last_seg;
  logic [13:0]        mag_u, mag_v;
  logic               slot_free;
  logic signed [9:0]  cval;
  logic [7:0]         chi, ylo, yhi;

  assign slot_free = !out_valid_r || out_pop;
  assign last_seg  = (seg_r + 6'd1) == cfg.n;

  function automatic logic acc_sign();
    return (state_r == B_U_WAIT) ? acc_u_r[14] : acc_v_r[14];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:     if (head_valid && head.render) state_nxt = B_ANG_GO;
      B_ANG_GO:   state_nxt = B_ANG_WAIT;
      B_ANG_WAIT: if (div_rsp.done) state_nxt = B_MUL;
      B_MUL:      state_nxt = B_GET;
      B_GET:      state_nxt = (mstep_r == ST_LAST) ? B_ADDR : B_MUL;
      B_ADDR:     state_nxt = B_READ;
      B_READ:     state_nxt = last_seg ? B_Y_GO : B_MUL;
      B_Y_GO:     state_nxt = B_Y_WAIT;
      B_Y_WAIT:   if (div_rsp.done) state_nxt = B_U_GO;
      B_U_GO:     state_nxt = B_U_WAIT;
      B_U_WAIT:   if (div_rsp.done) state_nxt = B_V_GO;
      B_V_GO:     state_nxt = B_V_WAIT;
      B_V_WAIT:   if (div_rsp.done) state_nxt = B_OUT;
      B_OUT:      if (slot_free) state_nxt = B_IDLE;
      default:    state_nxt = B_IDLE;
    endcase
  end

  // datapath helpers
  always_comb begin
    pass  = mstep_r >= ST_COS;
    lstep = pass ? 3'(mstep_r - ST_COS) : mstep_r[2:0];
    ang   = cfg.base + offq_r[11:0];
    ang_p = pass ? ang + 12'd1024 : ang;
    tq    = ang_p[10] ? 11'd1024 - {1'b0, ang_p[9:0]} : {1'b0, ang_p[9:0]};
    uq    = {tq, 20'b0};

    pabs  = p_r[32] ? 33'(-p_r) : 33'(p_r);
    snabs = sn_r[31] ? 32'(-sn_r) : 32'(sn_r);
    csabs = cs_r[31] ? 32'(-cs_r) : 32'(cs_r);
    dxabs = cmd_r.dx2[10] ? 11'(-cmd_r.dx2) : 11'(cmd_r.dx2);
    dyabs = cmd_r.dy2[10] ? 11'(-cmd_r.dy2) : 11'(cmd_r.dy2);

    sq30 = pneg_r ? -$signed({1'b0, prod_r[61:30]}) : $signed({1'b0, prod_r[61:30]});
    sp   = pneg_r ? -$signed({1'b0, prod_r}) : $signed({1'b0, prod_r});

    // round Q30 to Q14, clip to the unit range
    rpos = sq30[32] ? 33'd0 : 33'(sq30);
    rsum = rpos + 33'd32768;
    rs   = rsum[32:16];
    mq   = (rs > 17'd16384) ? 15'd16384 : rs[14:0];
    trig = ang_p[11] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});

    bx   = {cfg.cx, 25'b0} + 39'(1 << 28);
    by   = {cfg.cy, 25'b0} + 39'(1 << 28);
    sx_f = accx_r[42:29];
    sy_f = accy_r[42:29];
    sx   = (!sx_f[13] && (sx_f < $signed({5'b0, cfg.w}))) ? sx_f[8:0] : (cfg.w - 9'd1) >> 1;
    sy   = (!sy_f[13] && (sy_f < $signed({5'b0, cfg.h}))) ? sy_f[8:0] : (cfg.h - 9'd1) >> 1;

    nrem  = {1'b0, offr_r} + {1'b0, arem_r};
    mag_u = (acc_u_r[14] ? 14'(-acc_u_r) : 14'(acc_u_r)) + 14'(cfg.n >> 1);
    mag_v = (acc_v_r[14] ? 14'(-acc_v_r) : 14'(acc_v_r)) + 14'(cfg.n >> 1);

    ylo  = cfg.full ? 8'd0 : LIM_LO;
    yhi  = cfg.full ? 8'd255 : LIM_Y_HI;
    chi  = cfg.full ? 8'd255 : LIM_C_HI;
    cval = $signed({2'b0, CHROMA_OFFSET}) +
           (acc_sign() ? -$signed({1'b0, div_rsp.quot[8:0]}) : $signed({1'b0, div_rsp.quot[8:0]}));
  end

  // outputs: multiplier operands, store port, divider
  always_comb begin
    ma = '0;
    mb = '0;
    mn = 1'b0;
    if (mstep_r < ST_ZS) begin
      priority case (lstep)
        LS_U2:   begin ma = uq;  mb = uq; end
        LS_H9:   begin ma = PC9; mb = u2_r; end
        LS_R:    begin ma = pabs[30:0]; mb = uq; mn = p_r[32]; end
        default: begin ma = pabs[30:0]; mb = u2_r; mn = p_r[32]; end
      endcase
    end else begin
      priority case (mstep_r)
        ST_ZS:   begin ma = 31'(sin_r[15] ? -sin_r : sin_r); mb = 31'(cfg.zq); mn = sin_r[15]; end
        ST_ZC:   begin ma = 31'(cos_r[15] ? -cos_r : cos_r); mb = 31'(cfg.zq); mn = cos_r[15]; end
        ST_X0:   begin ma = 31'(dxabs); mb = csabs[30:0]; mn = cmd_r.dx2[10] ^ cs_r[31]; end
        ST_X1:   begin ma = 31'(dyabs); mb = snabs[30:0]; mn = cmd_r.dy2[10] ^ sn_r[31]; end
        ST_Y0:   begin ma = 31'(dxabs); mb = snabs[30:0]; mn = cmd_r.dx2[10] ^ sn_r[31]; end
        default: begin ma = 31'(dyabs); mb = csabs[30:0]; mn = cmd_r.dy2[10] ^ cs_r[31]; end
      endcase
    end

    head_pop  = (state_r == B_IDLE) && head_valid;
    ram_we    = (state_r == B_IDLE) && head_valid && !head.render;
    ram_wdata = {head.y, head.u, head.v};
    ram_addr  = ram_we ? AW'(int'(head.py) * MAX_WIDTH + int'(head.px))
                       : AW'(int'(sy) * MAX_WIDTH + int'(sx));

    div_req.start    = (state_r == B_ANG_GO) || (state_r == B_Y_GO) ||
                       (state_r == B_U_GO) || (state_r == B_V_GO);
    div_req.divisor  = cfg.n;
    unique case (state_r)
      B_Y_GO:  div_req.dividend = acc_y_r + 14'(cfg.n >> 1);
      B_U_GO:  div_req.dividend = mag_u;
      B_V_GO:  div_req.dividend = mag_v;
      default: div_req.dividend = 14'd4096;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (head_valid) begin
            cmd_r <= head;
          end
        end
        B_ANG_WAIT: begin
          astep_r <= div_rsp.quot[12:0];
          arem_r  <= div_rsp.rem;
          seg_r   <= '0;
          offq_r  <= '0;
          offr_r  <= '0;
          mstep_r <= '0;
          acc_y_r <= '0;
          acc_u_r <= '0;
          acc_v_r <= '0;
          accx_r  <= 43'(bx);
          accy_r  <= 43'(by);
        end
        B_MUL: begin
          prod_r <= 62'(ma) * 62'(mb);
          pneg_r <= mn;
        end
        B_GET: begin
          mstep_r <= mstep_r + 5'd1;
          if (mstep_r < ST_ZS) begin
            unique case (lstep)
              LS_U2:   u2_r <= prod_r[60:30];
              LS_H9:   p_r  <= PC7 + sq30;
              LS_H5:   p_r  <= PC5 + sq30;
              LS_H3:   p_r  <= PC3 + sq30;
              LS_H1:   p_r  <= PC1 + sq30;
              LS_R: begin
                if (pass) cos_r <= trig;
                else      sin_r <= trig;
              end
              default: ;
            endcase
          end else begin
            priority case (mstep_r)
              ST_ZS:   sn_r   <= sp[31:0];
              ST_ZC:   cs_r   <= sp[31:0];
              ST_X0:   accx_r <= accx_r + sp[42:0];
              ST_X1:   accx_r <= accx_r - sp[42:0];
              default: accy_r <= accy_r + sp[42:0];
            endcase
          end
        end
        B_READ: begin
          acc_y_r <= acc_y_r + 14'(ram_rdata[23:16]);
          acc_u_r <= acc_u_r + $signed({7'b0, ram_rdata[15:8]}) - 15'sd128;
          acc_v_r <= acc_v_r + $signed({7'b0, ram_rdata[7:0]}) - 15'sd128;
          // advance to the next segment angle
          seg_r   <= seg_r + 6'd1;
          mstep_r <= '0;
          accx_r  <= 43'(bx);
          accy_r  <= 43'(by);
          if (nrem >= {1'b0, cfg.n}) begin
            offr_r <= 6'(nrem - {1'b0, cfg.n});
            offq_r <= offq_r + astep_r + 13'd1;
          end else begin
            offr_r <= nrem[5:0];
            offq_r <= offq_r + astep_r;
          end
        end
        B_Y_WAIT: begin
          if (div_rsp.done) begin
            res_y_r <= (div_rsp.quot < 14'(ylo)) ? ylo :
                       (div_rsp.quot > 14'(yhi)) ? yhi : div_rsp.quot[7:0];
          end
        end
        B_U_WAIT: begin
          if (div_rsp.done) begin
            res_u_r <= (cval < $signed({2'b0, LIM_LO}) && !cfg.full) ? LIM_LO :
                       (cval > $signed({2'b0, chi})) ? chi : cval[7:0];
          end
        end
        B_V_WAIT: begin
          if (div_rsp.done) begin
            res_v_r <= (cval < $signed({2'b0, LIM_LO}) && !cfg.full) ? LIM_LO :
                       (cval > $signed({2'b0, chi})) ? chi : cval[7:0];
          end
        end
        B_OUT: begin
          if (slot_free) begin
            out_y_r     <= res_y_r;
            out_u_r     <= res_u_r;
            out_v_r     <= res_v_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_luma_out = out_y_r;
  assign out_cb_out   = out_u_r;
  assign out_cr_out   = out_v_r;

endmodule

// File: hdl/kaleidoscope_pixel_sampler.sv
// Kaleidoscope sampler over a YUV 4:4:4 frame store of MAX_WIDTH x MAX_HEIGHT words.
// A load item writes one store word from the idle state of the back end; loads and
// renders pass a two-entry command queue, so pushes continue while the back end works.
// For N segments, a render item runs 18 multiplies per segment (two polynomial sines,
// zoom and rotation) through one shared 31x31 multiplier, then one read of the
// single-port frame store; the angle step and the three averages go through a serial
// divider.
// The store has no reset; read only pixels that were loaded.
module kaleidoscope_pixel_sampler #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_SEGMENTS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_opcode,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [7:0]  in_luma_in,
  input  logic [7:0]  in_cb_in,
  input  logic [7:0]  in_cr_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_luma_out,
  output logic [7:0]  out_cb_out,
  output logic [7:0]  out_cr_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ksps_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [5:0]  seg_r;
  logic [11:0] angle_r;
  logic [15:0] zoom_r;
  logic [12:0] cx_r, cy_r;
  logic [8:0]  fw_r, fh_r;
  logic        full_r;

  ksps_cfg_t     cfg;
  ksps_cmd_t     head;
  logic          head_valid, head_pop;
  ksps_div_req_t div_req;
  ksps_div_rsp_t div_rsp;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= 6'd3;
      angle_r <= 12'd0;
      zoom_r  <= 16'd16384;
      cx_r    <= 13'd2040;
      cy_r    <= 13'd2040;
      fw_r    <= 9'd256;
      fh_r    <= 9'd256;
      full_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEGMENTS: seg_r   <= cfg_data[5:0];
        CFG_ANGLE:    angle_r <= cfg_data[11:0];
        CFG_ZOOM:     zoom_r  <= cfg_data;
        CFG_CX:       cx_r    <= cfg_data[12:0];
        CFG_CY:       cy_r    <= cfg_data[12:0];
        CFG_WIDTH:    fw_r    <= cfg_data[8:0];
        CFG_HEIGHT:   fh_r    <= cfg_data[8:0];
        CFG_RANGE:    full_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate the segment, zoom, width and height registers to their legal ranges
  always_comb begin
    cfg.n = (seg_r == 6'd0) ? 6'd1 :
            (int'(seg_r) > MAX_SEGMENTS) ? 6'(MAX_SEGMENTS) : seg_r;
    cfg.zq = (zoom_r < ZOOM_MIN) ? ZOOM_MIN : (zoom_r > ZOOM_MAX) ? ZOOM_MAX : zoom_r;
    cfg.w = (fw_r == 9'd0) ? 9'd1 : (int'(fw_r) > MAX_WIDTH) ? 9'(MAX_WIDTH) : fw_r;
    cfg.h = (fh_r == 9'd0) ? 9'd1 : (int'(fh_r) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : fh_r;
    cfg.base = angle_r;
    cfg.cx   = cx_r;
    cfg.cy   = cy_r;
    cfg.full = full_r;
  end

  ksps_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg,
    .in_push, .in_full, .in_opcode, .in_pixel_x, .in_pixel_y,
    .in_luma_in, .in_cb_in, .in_cr_in,
    .head_valid, .head, .head_pop
  );

  ksps_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst_n, .cfg, .head_valid, .head, .head_pop,
    .div_req, .div_rsp,
    .ram_we, .ram_addr, .ram_wdata, .ram_rdata,
    .out_empty, .out_pop, .out_luma_out, .out_cb_out, .out_cr_out
  );

  ksps_div u_div (
    .clk, .rst_n, .req(div_req), .rsp(div_rsp)
  );

  ksps_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_store (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata_r(ram_rdata)
  );

`ifndef ASSERT_OFF
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid)
    else $error("command taken from an empty queue");

  a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> !div_rsp.busy && $past(div_rsp.busy))
    else $error("divider done without a running division");
`endif

endmodule
